// ----- rtl/two_link_forward_kinematics_assert.svh -----
// Assertion macros for the two-link forward kinematics block.
`ifndef TWO_LINK_FORWARD_KINEMATICS_ASSERT_SVH
`define TWO_LINK_FORWARD_KINEMATICS_ASSERT_SVH

`define TLFK_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define TLFK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tlfk_pkg.sv -----
package tlfk_pkg;

    localparam int ANGLE_W = 16;
    localparam int LEN_W   = 16;
    localparam int OUT_W   = 18;
    localparam int CW      = 34;   // CORDIC x/y/z width, Q30 with headroom
    localparam int TABLE_LEN = 24;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [CW-1:0] GAIN_Q30  = 34'sd652032874;

    localparam logic [3:0] REG_L1   = 4'd0;
    localparam logic [3:0] REG_L2   = 4'd1;
    localparam logic [3:0] REG_OFF1 = 4'd2;
    localparam logic [3:0] REG_OFF2 = 4'd3;

    localparam logic signed [CW-1:0] ATAN_Q30 [TABLE_LEN] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
        34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
        34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
        34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
        34'sd1023, 34'sd511, 34'sd255, 34'sd127
    };

    // Angle wrap into [-pi, pi); input range needs at most three corrections.
    function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] v);
        logic signed [17:0] r;
        r = v;
        for (int k = 0; k < 3; k++) begin
            if (r >= PI_Q13) begin
                r = r - TWO_PI_Q13;
            end else if (r < -PI_Q13) begin
                r = r + TWO_PI_Q13;
            end
        end
        return r;
    endfunction

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_lane_t;

endpackage

// ----- rtl/tlfk_cordic.sv -----
// Pipelined rotation-mode CORDIC; one stage per register, advance on enable.
module tlfk_cordic #(
    parameter int STAGES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [17:0]            angle,
    output logic                          out_valid,
    output logic signed [tlfk_pkg::CW-1:0] cos_q30,
    output logic signed [tlfk_pkg::CW-1:0] sin_q30
);
    localparam int NST = (STAGES < tlfk_pkg::TABLE_LEN) ? STAGES : tlfk_pkg::TABLE_LEN;

    tlfk_pkg::cordic_lane_t lane_reg [NST+1];
    tlfk_pkg::cordic_lane_t lane_next [NST+1];

    logic signed [17:0] folded;
    logic               fold_neg;

    always_comb begin
        folded   = angle;
        fold_neg = 1'b0;
        if (angle > tlfk_pkg::HALF_PI_Q13) begin
            folded   = angle - tlfk_pkg::PI_Q13;
            fold_neg = 1'b1;
        end else if (angle < -tlfk_pkg::HALF_PI_Q13) begin
            folded   = angle + tlfk_pkg::PI_Q13;
            fold_neg = 1'b1;
        end
        lane_next[0].valid = in_valid;
        lane_next[0].neg   = fold_neg;
        lane_next[0].x     = tlfk_pkg::GAIN_Q30;
        lane_next[0].y     = '0;
        lane_next[0].z     = {folded[tlfk_pkg::CW-18:0], 17'd0};
        for (int i = 0; i < NST; i++) begin
            lane_next[i+1].valid = lane_reg[i].valid;
            lane_next[i+1].neg   = lane_reg[i].neg;
            if (!lane_reg[i].z[tlfk_pkg::CW-1]) begin
                lane_next[i+1].x = lane_reg[i].x - (lane_reg[i].y >>> i);
                lane_next[i+1].y = lane_reg[i].y + (lane_reg[i].x >>> i);
                lane_next[i+1].z = lane_reg[i].z - tlfk_pkg::ATAN_Q30[i];
            end else begin
                lane_next[i+1].x = lane_reg[i].x + (lane_reg[i].y >>> i);
                lane_next[i+1].y = lane_reg[i].y - (lane_reg[i].x >>> i);
                lane_next[i+1].z = lane_reg[i].z + tlfk_pkg::ATAN_Q30[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i <= NST; i++) begin
            if (!aresetn) begin
                lane_reg[i].valid <= 1'b0;
            end else if (en) begin
                lane_reg[i].valid <= lane_next[i].valid;
            end
            if (en) begin
                lane_reg[i].neg <= lane_next[i].neg;
                lane_reg[i].x   <= lane_next[i].x;
                lane_reg[i].y   <= lane_next[i].y;
                lane_reg[i].z   <= lane_next[i].z;
            end
        end
    end

    assign out_valid = lane_reg[NST].valid;
    assign cos_q30   = lane_reg[NST].neg ? -lane_reg[NST].x : lane_reg[NST].x;
    assign sin_q30   = lane_reg[NST].neg ? -lane_reg[NST].y : lane_reg[NST].y;
endmodule

// ----- rtl/two_link_forward_kinematics.sv -----
// Channel   Dir  Payload (low bit first)                        Handshake
// s_axis    in   tdata: first_joint_angle[15:0], second[31:16]   tvalid/tready
// m_axis    out  tdata: tip_x[17:0], tip_y[35:18], pad to 40     tvalid/tready
// cfg       in   cfg_index (register number), cfg_data[15:0]     cfg_valid/cfg_ready
// One beat per cycle sustained while m_axis_tready is high. Pipeline stages:
// offset/wrap, sum wrap, CORDIC fold, the CORDIC stages (max 24), multiply, sum, round.
// Synchronous active-low reset clears all valid bits; config registers return to defaults.
// A stall at m_axis freezes the whole pipeline, so s_axis_tready is low only while
// a result waits in the output register and m_axis_tready is low.
`include "two_link_forward_kinematics_assert.svh"
module two_link_forward_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // first_joint_angle, second_joint_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // tip_x, tip_y, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int CW = tlfk_pkg::CW;

    logic [15:0]        l1_reg, l2_reg;
    logic signed [15:0] off1_reg, off2_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg <= 16'd4096; l2_reg <= 16'd4096;
            off1_reg <= '0; off2_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tlfk_pkg::REG_L1:   l1_reg   <= cfg_data;
                tlfk_pkg::REG_L2:   l2_reg   <= cfg_data;
                tlfk_pkg::REG_OFF1: off1_reg <= cfg_data;
                tlfk_pkg::REG_OFF2: off2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output skid: pipeline advances when the output register can take a beat.
    logic        out_v_reg;
    logic [39:0] out_d_reg;
    logic        en;
    logic        last_v;
    assign en = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Stage A: offsets and wrap.
    logic               a_v_reg;
    logic signed [17:0] t1_reg, t2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) a_v_reg <= 1'b0;
        else if (en) a_v_reg <= s_axis_tvalid;
        if (en) begin
            t1_reg <= tlfk_pkg::wrap_angle(18'(signed'(s_axis_tdata[15:0])) - 18'(off1_reg));
            t2_reg <= tlfk_pkg::wrap_angle(18'(signed'(s_axis_tdata[31:16])) - 18'(off2_reg));
        end
    end

    // Stage B: joint sum.
    logic               b_v_reg;
    logic signed [17:0] b_t1_reg, t12_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) b_v_reg <= 1'b0;
        else if (en) b_v_reg <= a_v_reg;
        if (en) begin
            b_t1_reg <= t1_reg;
            t12_reg  <= tlfk_pkg::wrap_angle(t1_reg + t2_reg);
        end
    end

    logic                 c1_v, c2_v;
    logic signed [CW-1:0] c1, s1, c12, s12;
    tlfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic1 (
        .aclk, .aresetn, .en, .in_valid(b_v_reg), .angle(b_t1_reg),
        .out_valid(c1_v), .cos_q30(c1), .sin_q30(s1));
    tlfk_cordic #(.STAGES(CORDIC_STAGES)) u_cordic2 (
        .aclk, .aresetn, .en, .in_valid(b_v_reg), .angle(t12_reg),
        .out_valid(c2_v), .cos_q30(c12), .sin_q30(s12));

    // Stage M: four products (17 x 34 signed each, |value| small enough).
    logic                  m_v_reg;
    logic signed [51:0]    px1_reg, px2_reg, py1_reg, py2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_v_reg <= 1'b0;
        else if (en) m_v_reg <= c1_v;
        if (en) begin
            px1_reg <= 52'(signed'({1'b0, l1_reg}) * c1);
            py1_reg <= 52'(signed'({1'b0, l1_reg}) * s1);
            px2_reg <= 52'(signed'({1'b0, l2_reg}) * c12);
            py2_reg <= 52'(signed'({1'b0, l2_reg}) * s12);
        end
    end

    // Stage S: exact sums plus the rounding constant (half an output LSB).
    logic               s_v_reg;
    logic signed [52:0] sx_reg, sy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) s_v_reg <= 1'b0;
        else if (en) s_v_reg <= m_v_reg;
        if (en) begin
            sx_reg <= 53'(px1_reg) + 53'(px2_reg) + 53'sd536870912;
            sy_reg <= 53'(py1_reg) + 53'(py2_reg) + 53'sd536870912;
        end
    end

    function automatic logic [17:0] sat_out(input logic signed [52:0] acc);
        logic signed [22:0] r;
        r = acc[52:30];
        if (r > 23'sd131071) return 18'h1FFFF;
        if (r < -23'sd131072) return 18'h20000;
        return r[17:0];
    endfunction

    assign last_v = s_v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= last_v;
        if (en) out_d_reg <= {4'd0, sat_out(sy_reg), sat_out(sx_reg)};
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    `TLFK_ASSERT_IMPL(a_lanes_agree, aclk, aresetn, 1'b1, c1_v == c2_v,
        "CORDIC lanes out of step")
    `TLFK_ASSERT_NEXT(a_stall_holds, aclk, aresetn, out_v_reg && !m_axis_tready,
        out_v_reg && $stable(out_d_reg), "stalled result changed")
    `TLFK_ASSERT_NEXT(a_pad_zero, aclk, aresetn, 1'b1, m_axis_tdata[39:36] == 4'd0,
        "tdata pad not zero")
endmodule
